[rtl/spl_pkg.sv]
package spl_pkg;

  localparam int unsigned SMP_W  = 24;
  localparam int unsigned COEF_W = 23;
  localparam int unsigned DIV_STEPS = 23;
  localparam int unsigned CNT_W  = $clog2(DIV_STEPS);

  localparam logic [SMP_W-1:0]  ONE_Q23       = 24'd8388608;
  localparam logic [SMP_W-1:0]  CEILING_RST   = 24'd8220836;
  localparam logic [COEF_W-1:0] COEFF_RST     = 23'd8384804;

  // register indexes on the configuration port
  localparam logic CFG_CEILING = 1'b0;
  localparam logic CFG_COEFF   = 1'b1;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    logic load;      // capture item, peak and limit flag
    logic div_step;  // one restoring division step
    logic rel_mul;   // coeff * (target - gain)
    logic gain_upd;  // write new gain
    logic mul_l;     // left * gain
    logic mul_r;     // right * gain
    logic out_load;  // fill output register
  } ctl_cmd_t;

  typedef struct packed {
    logic lim;       // peak above ceiling
    logic div_done;  // last division step
    logic out_busy;  // output register still held
  } ctl_sts_t;

endpackage

[rtl/spl_ctrl.sv]
module spl_ctrl import spl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_REL   = 7'b0000100,
    S_GAIN  = 7'b0001000,
    S_MUL_L = 7'b0010000,
    S_MUL_R = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_acc;
        if (in_acc) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = sts.lim;
        if (!sts.lim || sts.div_done) state_nxt = S_REL;
      end
      S_REL: begin
        cmd.rel_mul = 1'b1;
        state_nxt   = S_GAIN;
      end
      S_GAIN: begin
        cmd.gain_upd = 1'b1;
        state_nxt    = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_l = 1'b1;
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_r = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[rtl/spl_dpath.sv]
module spl_dpath import spl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [SMP_W-1:0]  cfg_wdata,
  input  logic              out_stall,
  output logic              out_valid,
  output out_item_t         out_data,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts
);

  logic [SMP_W-1:0]        ceil_r;
  logic [COEF_W-1:0]       coeff_r;
  logic [SMP_W-1:0]        gain_r;
  logic signed [SMP_W-1:0] l_r, r_r, left_r;
  logic [SMP_W-2:0]        peak_r, rem_r, quo_r;
  logic                    lim_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [46:0]             prod_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [SMP_W-2:0]        mag_l, mag_r, peak;
  logic [SMP_W-1:0]        rem2, rem_sub, tgt, dlt, prod_hi;
  logic                    rem_ge;
  logic signed [SMP_W:0]   ma, mb;
  logic signed [2*SMP_W+1:0] mp;

  // magnitude with full-scale negative pinned to the largest positive code
  function automatic logic [SMP_W-2:0] mag_sat(input logic signed [SMP_W-1:0] x);
    logic [SMP_W-1:0] neg;
    neg = -x;
    if (!x[SMP_W-1])            return x[SMP_W-2:0];
    else if (neg[SMP_W-1])      return '1;
    else                        return neg[SMP_W-2:0];
  endfunction

  assign mag_l = mag_sat(in_data.left_in);
  assign mag_r = mag_sat(in_data.right_in);
  assign peak  = (mag_l > mag_r) ? mag_l : mag_r;

  // restoring divider: remainder stays below peak
  assign rem2    = {rem_r, 1'b0};
  assign rem_ge  = rem2 >= {1'b0, peak_r};
  assign rem_sub = rem2 - {1'b0, peak_r};

  assign tgt     = lim_r ? {1'b0, quo_r} : ONE_Q23;
  assign dlt     = tgt - gain_r;
  assign prod_hi = prod_r[46:23];

  // one shared multiplier
  always_comb begin
    ma = {2'b00, coeff_r};
    mb = {1'b0, dlt};
    if (cmd.mul_l) begin
      ma = {l_r[SMP_W-1], l_r};
      mb = {1'b0, gain_r};
    end else if (cmd.mul_r) begin
      ma = {r_r[SMP_W-1], r_r};
      mb = {1'b0, gain_r};
    end
  end
  assign mp = ma * mb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= CEILING_RST;
      coeff_r <= COEFF_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CEILING: ceil_r  <= cfg_wdata;
        CFG_COEFF:   coeff_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= ONE_Q23;
    end else if (cmd.gain_upd) begin
      gain_r <= (tgt < gain_r) ? tgt : tgt - prod_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_r    <= in_data.left_in;
      r_r    <= in_data.right_in;
      peak_r <= peak;
      lim_r  <= {1'b0, peak} > ceil_r;
      rem_r  <= ceil_r[SMP_W-2:0];
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[SMP_W-2:0] : rem2[SMP_W-2:0];
      quo_r <= {quo_r[SMP_W-3:0], rem_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.rel_mul || cmd.mul_l || cmd.mul_r) prod_r <= mp[46:0];
    if (cmd.mul_r) left_r <= prod_hi;
    if (cmd.out_load) out_data_r <= '{left_out: left_r, right_out: prod_hi};
  end

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.out_load)  out_valid_r <= 1'b1;
    else if (!out_stall)    out_valid_r <= 1'b0;
  end

  assign sts.lim      = lim_r;
  assign sts.div_done = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/stereo_peak_limiter.sv]
// Channel   Dir  Payload      Handshake
// in_       in   in_item_t    in_valid / in_stall   (stereo pair, Q1.23)
// out_      out  out_item_t   out_valid / out_stall (limited pair, Q1.23)
// cfg_      in   24b data     cfg_we, cfg_addr (0 ceiling, 1 release coeff)
//
// One item at a time. An item whose peak is above the ceiling also passes
// through the 23-step serial divider for the target gain; an item within
// the ceiling skips the division steps.
// The output register holds a result while out_stall is high; the next item
// is accepted meanwhile and waits in the last step until the register frees.
// Synchronous reset restores gain to unity and the register defaults.
module stereo_peak_limiter import spl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result items
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // configuration writes
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [SMP_W-1:0] cfg_wdata
);

  // controller sequences: capture -> divide (limited only) -> release
  // multiply -> gain update -> left multiply -> right multiply -> output
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: gain register, divider, one shared 25x25 multiplier, out reg
  spl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[rtl/spl_checker.sv]
module spl_checker import spl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted back to back");

  // a new result only appears while an item is in work
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item in work");

  // an accepted item keeps the block busy and does not finish too early
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##4 in_stall)
    else $error("item finished too early");

endmodule

bind stereo_peak_limiter spl_checker u_spl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
